FILE: design/eltc_pkg.sv
// ----------------------------------------------------------------------------
// eltc_pkg
// shared types and constants of the edge list to csr builder
// ----------------------------------------------------------------------------
package eltc_pkg;
  localparam int unsigned MAX_NODES_DEF  = 1024;
  localparam int unsigned MAX_EDGES_DEF  = 4096;
  localparam int unsigned TYPE_WIDTH_DEF = 8;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned ETYPE_W  = 8;
  localparam int unsigned IDX_W    = 13;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned NC_W     = 11;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD      = 2'd0,
    OP_BUILD     = 2'd1,
    OP_RD_OFFSET = 2'd2,
    OP_RD_EDGE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FROZEN    = 3'd1,
    ST_FULL      = 3'd2,
    ST_RANGE     = 3'd3,
    ST_NOT_BUILT = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_CNT_RD, S_CNT_WAIT, S_CNT_RMW, S_PFX_RD, S_PFX_WB,
    S_SC_RD, S_SC_WAIT, S_SC_CUR, S_SC_WB, S_RD_WAIT, S_RD_DONE, S_OUT
  } state_t;
endpackage

FILE: design/eltc_ram.sv
// ----------------------------------------------------------------------------
// eltc_ram
// single port synchronous ram with registered read
// ----------------------------------------------------------------------------
module eltc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: design/edge_list_to_csr_builder_core.sv
// ----------------------------------------------------------------------------
// edge_list_to_csr_builder_core
// coo to csr conversion by counting sort over on-chip memories
// ----------------------------------------------------------------------------
// load and register-only answers: result registered at acceptance; reads pass
//   through S_RD_WAIT and S_RD_DONE; next transaction accepted the cycle after
//   its result is taken; build: clears the offset memory, counts edges per
//   source node, forms the prefix sums and cursors, then scatters the edges
// reset: synchronous active low, clears control state and counts;
//   the stores hold no reset, the offset memory is cleared at build start
// ----------------------------------------------------------------------------
module edge_list_to_csr_builder_core #(
  parameter int unsigned MAX_NODES  = eltc_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_EDGES  = eltc_pkg::MAX_EDGES_DEF,
  parameter int unsigned TYPE_WIDTH = eltc_pkg::TYPE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [eltc_pkg::NC_W-1:0]     cfg_node_count,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [eltc_pkg::OP_W-1:0]     in_op,
  input  logic [eltc_pkg::ID_W-1:0]     in_source_id,
  input  logic [eltc_pkg::ID_W-1:0]     in_target_id,
  input  logic [eltc_pkg::ETYPE_W-1:0]  in_edge_type,
  input  logic [eltc_pkg::IDX_W-1:0]    in_read_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [eltc_pkg::STATUS_W-1:0] out_status,
  output logic [eltc_pkg::ID_W-1:0]     out_read_data,
  output logic [eltc_pkg::ETYPE_W-1:0]  out_read_type,
  output logic [eltc_pkg::IDX_W-1:0]    out_dropped_total,
  output logic [eltc_pkg::IDX_W-1:0]    out_kept_total
);
  import eltc_pkg::*;

  localparam int unsigned EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned EC_W = $clog2(MAX_EDGES + 1);
  localparam int unsigned OD   = MAX_NODES + 1;
  localparam int unsigned OA_W = $clog2(OD);
  localparam int unsigned NN_W = $clog2(MAX_NODES + 1);
  localparam int unsigned CA_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned RAW_W = 2 * ID_W + TYPE_WIDTH;
  localparam int unsigned CSR_W = ID_W + TYPE_WIDTH;
  // offsets and cursors may exceed the store depth by one
  localparam int unsigned OV_W = EC_W + 1;

  // control state
  state_t state_r, state_nxt;
  logic   frozen_r;
  logic [NC_W-1:0] node_count_r;
  logic [EC_W-1:0] loaded_r;
  logic [EC_W-1:0] dropped_r;
  logic [OV_W-1:0] kept_r;
  logic [NN_W-1:0] built_r;
  logic [EC_W:0]   ecnt_r;      // edge walk counter
  logic [OA_W:0]   ncnt_r;      // node walk counter
  logic [OV_W-1:0] acc_r;       // running prefix sum
  // latched transaction
  op_t             op_r;
  logic [IDX_W-1:0] idx_r;
  // result register
  logic            out_valid_r;
  logic [STATUS_W-1:0] st_r;
  logic [ID_W-1:0] data_r;
  logic [ETYPE_W-1:0] rtype_r;
  // scatter edge held across its steps
  logic [ID_W-1:0] e_src_r, e_dst_r;
  logic [TYPE_WIDTH-1:0] e_typ_r;
  logic            e_ok_r;

  // memories
  logic            raw_we, off_we, cur_we, csr_we;
  logic [EA_W-1:0] raw_a, csr_a;
  logic [OA_W-1:0] off_a;
  logic [CA_W-1:0] cur_a;
  logic [RAW_W-1:0] raw_wd, raw_rd;
  logic [OV_W-1:0] off_wd, off_rd, cur_wd, cur_rd;
  logic [CSR_W-1:0] csr_wd, csr_rd;

  eltc_ram #(.WIDTH(RAW_W), .DEPTH(MAX_EDGES)) u_raw (
    .clk, .we(raw_we), .addr(raw_a), .wdata(raw_wd), .rdata(raw_rd));
  eltc_ram #(.WIDTH(OV_W), .DEPTH(OD)) u_off (
    .clk, .we(off_we), .addr(off_a), .wdata(off_wd), .rdata(off_rd));
  eltc_ram #(.WIDTH(OV_W), .DEPTH(MAX_NODES)) u_cur (
    .clk, .we(cur_we), .addr(cur_a), .wdata(cur_wd), .rdata(cur_rd));
  eltc_ram #(.WIDTH(CSR_W), .DEPTH(MAX_EDGES)) u_csr (
    .clk, .we(csr_we), .addr(csr_a), .wdata(csr_wd), .rdata(csr_rd));

  // fields of the raw edge just read
  logic [ID_W-1:0] r_src, r_dst;
  logic [TYPE_WIDTH-1:0] r_typ;
  assign r_src = raw_rd[RAW_W-1 -: ID_W];
  assign r_dst = raw_rd[RAW_W-ID_W-1 -: ID_W];
  assign r_typ = raw_rd[TYPE_WIDTH-1:0];

  // clamped node count, latched into built_r at build start
  logic [NN_W-1:0] nc_clamp;
  assign nc_clamp = (32'(node_count_r) > MAX_NODES) ? NN_W'(MAX_NODES)
                                                    : NN_W'(node_count_r);
  logic r_ok;
  assign r_ok = (32'(r_src) < 32'(built_r)) && (32'(r_dst) < 32'(built_r));

  logic in_fire, out_fire;
  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign cfg_ready = 1'b1;

  logic ecnt_end;
  assign ecnt_end = (ecnt_r[EC_W-1:0] == loaded_r);

  // status known at acceptance; reads may still turn into a range error
  logic [STATUS_W-1:0] st_accept;
  always_comb begin
    st_accept = ST_OK;
    if (op_t'(in_op) == OP_LOAD || op_t'(in_op) == OP_BUILD) begin
      if (frozen_r) st_accept = ST_FROZEN;
      else if (op_t'(in_op) == OP_LOAD && 32'(loaded_r) >= MAX_EDGES)
        st_accept = ST_FULL;
    end else if (!frozen_r) begin
      st_accept = ST_NOT_BUILT;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (op_t'(in_op) == OP_BUILD && !frozen_r) state_nxt = S_CLEAR;
          else if ((op_t'(in_op) == OP_RD_OFFSET || op_t'(in_op) == OP_RD_EDGE)
                   && frozen_r) state_nxt = S_RD_WAIT;
          else state_nxt = S_OUT;
        end
      end
      S_CLEAR:    if (32'(ncnt_r) == OD - 1) state_nxt = S_CNT_RD;
      S_CNT_RD:   state_nxt = ecnt_end ? S_PFX_RD : S_CNT_WAIT;
      S_CNT_WAIT: state_nxt = S_CNT_RMW;
      S_CNT_RMW:  state_nxt = S_CNT_RD;
      S_PFX_RD:   state_nxt = (32'(ncnt_r) > 32'(built_r)) ? S_SC_RD : S_PFX_WB;
      S_PFX_WB:   state_nxt = S_PFX_RD;
      S_SC_RD:    state_nxt = ecnt_end ? S_OUT : S_SC_WAIT;
      S_SC_WAIT:  state_nxt = S_SC_CUR;
      S_SC_CUR:   state_nxt = S_SC_WB;
      S_SC_WB:    state_nxt = S_SC_RD;
      S_RD_WAIT:  state_nxt = S_RD_DONE;
      S_RD_DONE:  state_nxt = S_IDLE;
      S_OUT:      state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    raw_we = 1'b0; off_we = 1'b0; cur_we = 1'b0; csr_we = 1'b0;
    raw_a  = ecnt_r[EA_W-1:0];
    raw_wd = {in_source_id, in_target_id, TYPE_WIDTH'(in_edge_type)};
    off_a  = ncnt_r[OA_W-1:0];
    off_wd = '0;
    cur_a  = CA_W'(ncnt_r);
    cur_wd = acc_r;
    csr_a  = cur_rd[EA_W-1:0];
    csr_wd = {e_dst_r, e_typ_r};
    case (state_r)
      S_IDLE: begin
        raw_a  = loaded_r[EA_W-1:0];
        raw_we = in_fire && op_t'(in_op) == OP_LOAD && !frozen_r
                 && 32'(loaded_r) < MAX_EDGES;
        off_a  = OA_W'(in_read_index);
        csr_a  = EA_W'(in_read_index);
      end
      S_CLEAR: off_we = 1'b1;
      // raw edge is out: fetch its counter
      S_CNT_WAIT: off_a = OA_W'(32'(r_src) + 1);
      S_CNT_RMW: begin
        off_a  = OA_W'(32'(r_src) + 1);
        off_we = r_ok;
        off_wd = off_rd + OV_W'(1);
      end
      S_PFX_WB: begin
        off_we = 1'b1;
        off_wd = acc_r + off_rd;
        cur_we = (32'(ncnt_r) < 32'(built_r));
        cur_wd = acc_r + off_rd;
      end
      S_SC_CUR: cur_a = CA_W'(r_src);
      S_SC_WB: begin
        cur_a  = CA_W'(e_src_r);
        cur_we = e_ok_r;
        cur_wd = cur_rd + OV_W'(1);
        csr_we = e_ok_r && (32'(cur_rd) < MAX_EDGES);
      end
      // hold the read address so the data is still there in S_RD_DONE
      S_RD_WAIT: begin
        off_a = OA_W'(idx_r);
        csr_a = EA_W'(idx_r);
      end
      default: ;
    endcase
  end

  // the count pass issues the read for the following entry in the next cycle,
  // so the read-modify-write of one counter never overlaps with the next one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; frozen_r <= 1'b0; node_count_r <= '0; loaded_r <= '0;
      dropped_r <= '0; kept_r <= '0; built_r <= '0; out_valid_r <= 1'b0;
      ecnt_r <= '0; ncnt_r <= '0; acc_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) node_count_r <= cfg_node_count;
      if (out_fire) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (raw_we) loaded_r <= loaded_r + EC_W'(1);
            ncnt_r  <= '0;
            ecnt_r  <= '0;
            if (op_t'(in_op) == OP_BUILD && !frozen_r) begin
              dropped_r <= '0;
              built_r   <= nc_clamp;
            end
          end
        end
        S_CLEAR: ncnt_r <= ncnt_r + 1'b1;
        S_CNT_RD: begin
          if (ecnt_end) begin
            ncnt_r <= '0;
            acc_r  <= '0;
          end
        end
        S_CNT_RMW: begin
          if (!r_ok) dropped_r <= dropped_r + EC_W'(1);
          ecnt_r <= ecnt_r + 1'b1;
        end
        S_PFX_RD: begin
          if (32'(ncnt_r) > 32'(built_r)) begin
            ecnt_r <= '0;
            kept_r <= acc_r;
          end
        end
        S_PFX_WB: begin
          // off_rd holds the count of entry ncnt_r (entry 0 is zero)
          acc_r  <= acc_r + off_rd;
          ncnt_r <= ncnt_r + 1'b1;
        end
        S_SC_RD: if (ecnt_end) frozen_r <= 1'b1;
        S_SC_WB: ecnt_r <= ecnt_r + 1'b1;
        default: ;
      endcase
      if (state_nxt == S_OUT || state_r == S_RD_DONE) out_valid_r <= 1'b1;
    end
  end

  // prefix pass: entry i gets acc + count[i], acc being the sum of the
  // entries below i; the cursor of node i starts at the same value

  // payload registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_r    <= op_t'(in_op);
          idx_r   <= in_read_index;
          data_r  <= '0;
          rtype_r <= '0;
          st_r    <= st_accept;
        end
      end
      S_SC_WAIT: ;
      S_SC_CUR: begin
        e_src_r <= r_src;
        e_dst_r <= r_dst;
        e_typ_r <= r_typ;
        e_ok_r  <= r_ok;
      end
      S_SC_WB: ;
      S_RD_DONE: begin
        if (op_r == OP_RD_OFFSET) begin
          if (32'(idx_r) > 32'(built_r)) st_r <= ST_RANGE;
          else data_r <= ID_W'(off_rd);
        end else begin
          if (32'(idx_r) >= 32'(kept_r) || 32'(idx_r) >= MAX_EDGES)
            st_r <= ST_RANGE;
          else begin
            data_r  <= csr_rd[CSR_W-1 -: ID_W];
            rtype_r <= ETYPE_W'(csr_rd[TYPE_WIDTH-1:0]);
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_status        = st_r;
  assign out_read_data     = data_r;
  assign out_read_type     = rtype_r;
  assign out_dropped_total = frozen_r ? IDX_W'(dropped_r) : '0;
  assign out_kept_total    = frozen_r ? IDX_W'(kept_r) : '0;

`ifndef SYNTHESIS
  // no new transaction while a result waits
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_ready) else $error("accept while result pending");
  // a held result does not change
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(st_r) && $stable(data_r))
    else $error("result changed while stalled");
  // frozen never drops once set
  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    $past(frozen_r) && rst_n && $past(rst_n) |-> frozen_r)
    else $error("frozen cleared");
`endif
endmodule
